// ===== sv/grpw_pkg.sv =====
package grpw_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    localparam int DIM_W  = 10;
    localparam int ROW_W  = 9;
    localparam int COL_W  = 9;
    localparam int ELEV_W = 16;
    localparam int DIFF_W = ELEV_W + 1;
    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int AREA_W = ADDR_W + 1;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_STEP  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ROW = 2'd1,
        ST_NO_WALK = 2'd2
    } t_status;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [ELEV_W-1:0] elevation;
        logic [ROW_W-1:0]        start_row;
        logic                    coin;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0] path_row;
        logic [COL_W-1:0] path_col;
        logic             last_step;
        logic [1:0]       status;
    } t_out_item;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [AREA_W-1:0] area;
    } t_dims;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        addr;
        logic signed [ELEV_W-1:0] wdata;
    } t_mem_req;

endpackage

// ===== sv/grpw_store.sv =====
module grpw_store (
    input  logic                               i_clk,
    input  grpw_pkg::t_mem_req                 i_req,
    output logic signed [grpw_pkg::ELEV_W-1:0] o_rdata
);
    import grpw_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic signed [ELEV_W-1:0] r_mem [DEPTH];
    logic signed [ELEV_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/grpw_cfg.sv =====
module grpw_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [grpw_pkg::PADDR_W-1:0]  paddr,
    input  logic [grpw_pkg::PDATA_W-1:0]  pwdata,
    output logic [grpw_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output grpw_pkg::t_dims               o_dims
);
    import grpw_pkg::*;

    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [AREA_W-1:0] r_area;
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        if (r_width < DIM_W'(2)) begin
            w_eff = DIM_W'(2);
        end else if (r_width > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height < DIM_W'(2)) begin
            h_eff = DIM_W'(2);
        end else if (r_height > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(MAX_WIDTH);
            r_height <= DIM_W'(MAX_HEIGHT);
            r_area   <= AREA_W'(MAX_WIDTH * MAX_HEIGHT);
        end else begin
            if (wr_en && paddr[2] == REG_WIDTH) begin
                r_width <= pwdata[DIM_W-1:0];
            end
            if (wr_en && paddr[2] == REG_HEIGHT) begin
                r_height <= pwdata[DIM_W-1:0];
            end
            r_area <= AREA_W'(w_eff) * AREA_W'(h_eff);
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = PDATA_W'(r_width);
            REG_HEIGHT: prdata = PDATA_W'(r_height);
            default:    prdata = '0;
        endcase
    end

    assign o_dims.width  = w_eff;
    assign o_dims.height = h_eff;
    assign o_dims.area   = r_area;

endmodule

// ===== sv/grpw_walk.sv =====
module grpw_walk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  grpw_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output grpw_pkg::t_out_item                o_out_item,
    input  grpw_pkg::t_dims                    i_dims,
    output grpw_pkg::t_mem_req                 o_mem_req,
    input  logic signed [grpw_pkg::ELEV_W-1:0] i_mem_rdata
);
    import grpw_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_EXEC    = 9'b000000010,
        S_RD_HERE = 9'b000000100,
        S_RD_MID  = 9'b000001000,
        S_RD_UP   = 9'b000010000,
        S_RD_DN   = 9'b000100000,
        S_DIFF    = 9'b001000000,
        S_PICK    = 9'b010000000,
        S_EMIT    = 9'b100000000
    } t_state;

    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [ELEV_W-1:0] a,
        input logic signed [ELEV_W-1:0] b
    );
        logic signed [DIFF_W-1:0] d;
        d = {a[ELEV_W-1], a} - {b[ELEV_W-1], b};
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    t_state                   r_state,    n_state;
    t_in_item                 r_item,     n_item;
    logic [AREA_W-1:0]        r_load_pos, n_load_pos;
    logic [ROW_W-1:0]         r_row,      n_row;
    logic [COL_W-1:0]         r_col,      n_col;
    logic                     r_walking,  n_walking;
    logic [ADDR_W-1:0]        r_base,     n_base;
    logic signed [ELEV_W-1:0] r_here,     n_here;
    logic signed [ELEV_W-1:0] r_mid,      n_mid;
    logic signed [ELEV_W-1:0] r_up,       n_up;
    logic [DIFF_W-1:0]        r_du,       n_du;
    logic [DIFF_W-1:0]        r_dr,       n_dr;
    logic [DIFF_W-1:0]        r_dd,       n_dd;
    t_out_item                r_res,      n_res;
    t_out_item                r_out,      n_out;
    logic                     r_out_valid, n_out_valid;

    logic [ROW_W+DIM_W-1:0]   prod;
    logic                     load_ok;
    logic                     is_top;
    logic                     is_bot;
    logic [ROW_W-1:0]         pick_row;
    logic [COL_W-1:0]         next_col;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign load_ok  = (r_load_pos < i_dims.area);
    assign prod     = (ROW_W+DIM_W)'(r_row) * (ROW_W+DIM_W)'(i_dims.width);
    assign is_top   = (r_row == '0);
    assign is_bot   = ({1'b0, r_row} == i_dims.height - DIM_W'(1));
    assign next_col = r_col + COL_W'(1);

    // neighbour choice, right wins ties at the edges
    always_comb begin
        if (is_top) begin
            pick_row = (r_dr <= r_dd) ? r_row : r_row + ROW_W'(1);
        end else if (is_bot) begin
            pick_row = (r_dr <= r_du) ? r_row : r_row - ROW_W'(1);
        end else if (r_du < r_dr && r_du < r_dd) begin
            pick_row = r_row - ROW_W'(1);
        end else if (r_dr < r_du && r_dr < r_dd) begin
            pick_row = r_row;
        end else if (r_dd < r_du && r_dd < r_dr) begin
            pick_row = r_row + ROW_W'(1);
        end else if (r_du == r_dr || r_dr == r_dd) begin
            pick_row = r_row;
        end else begin
            pick_row = r_item.coin ? r_row - ROW_W'(1) : r_row + ROW_W'(1);
        end
    end

    always_comb begin
        o_mem_req.we    = 1'b0;
        o_mem_req.addr  = r_base;
        o_mem_req.wdata = r_item.elevation;
        case (r_state)
            S_EXEC: begin
                o_mem_req.we   = (r_item.action == ACT_LOAD) && load_ok;
                o_mem_req.addr = r_load_pos[ADDR_W-1:0];
            end
            S_RD_HERE: o_mem_req.addr = r_base;
            S_RD_MID:  o_mem_req.addr = r_base + ADDR_W'(1);
            S_RD_UP:   o_mem_req.addr = r_base + ADDR_W'(1) - ADDR_W'(i_dims.width);
            S_RD_DN:   o_mem_req.addr = r_base + ADDR_W'(1) + ADDR_W'(i_dims.width);
            default:   o_mem_req.addr = r_base;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_load_pos  = r_load_pos;
        n_row       = r_row;
        n_col       = r_col;
        n_walking   = r_walking;
        n_base      = r_base;
        n_here      = r_here;
        n_mid       = r_mid;
        n_up        = r_up;
        n_du        = r_du;
        n_dr        = r_dr;
        n_dd        = r_dd;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_item.action)
                    ACT_LOAD: begin
                        if (load_ok) begin
                            n_load_pos = r_load_pos + AREA_W'(1);
                        end
                        n_state = S_IDLE;
                    end
                    ACT_START: begin
                        n_load_pos = '0;
                        n_state    = S_EMIT;
                        if ({1'b0, r_item.start_row} >= i_dims.height) begin
                            n_walking = 1'b0;
                            n_res     = '{path_row: '0, path_col: '0, last_step: 1'b0,
                                          status: ST_BAD_ROW};
                        end else begin
                            n_walking = 1'b1;
                            n_row     = r_item.start_row;
                            n_col     = '0;
                            n_res     = '{path_row: r_item.start_row, path_col: '0,
                                          last_step: 1'b0, status: ST_OK};
                        end
                    end
                    ACT_STEP: begin
                        if (!r_walking || {1'b0, r_row} >= i_dims.height
                                || {1'b0, r_col} + DIM_W'(1) >= i_dims.width) begin
                            n_walking = 1'b0;
                            n_res     = '{path_row: '0, path_col: '0, last_step: 1'b0,
                                          status: ST_NO_WALK};
                            n_state   = S_EMIT;
                        end else begin
                            n_base  = ADDR_W'(prod + (ROW_W+DIM_W)'(r_col));
                            n_state = S_RD_HERE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_RD_HERE: n_state = S_RD_MID;
            S_RD_MID: begin
                n_here  = i_mem_rdata;
                n_state = S_RD_UP;
            end
            S_RD_UP: begin
                n_mid   = i_mem_rdata;
                n_state = S_RD_DN;
            end
            S_RD_DN: begin
                n_up    = i_mem_rdata;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_du    = abs_diff(r_here, r_up);
                n_dr    = abs_diff(r_here, r_mid);
                n_dd    = abs_diff(r_here, i_mem_rdata);
                n_state = S_PICK;
            end
            S_PICK: begin
                n_row = pick_row;
                n_col = next_col;
                n_res = '{path_row: pick_row, path_col: next_col, last_step: 1'b0,
                          status: ST_OK};
                if ({1'b0, next_col} == i_dims.width - DIM_W'(1)) begin
                    n_walking       = 1'b0;
                    n_res.last_step = 1'b1;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_load_pos  <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_walking   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_pos  <= n_load_pos;
            r_row       <= n_row;
            r_col       <= n_col;
            r_walking   <= n_walking;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_base <= n_base;
        r_here <= n_here;
        r_mid  <= n_mid;
        r_up   <= n_up;
        r_du   <= n_du;
        r_dr   <= n_dr;
        r_dd   <= n_dd;
        r_res  <= n_res;
        r_out  <= n_out;
    end

endmodule

// ===== sv/greedy_ridge_path_walk_unit.sv =====
// Greedy ridge path walk.
// Input channel (i_in_valid / o_in_ready / i_in_item) takes one item at a time:
// load a sample, start a walk at a row, or take one step right. Results leave
// on o_out_valid / i_out_ready / o_out_item; loads and unused actions give none.
// Map size is set over the APB port: width at 0x0, height at 0x4.
// States per item, from acceptance until the next item can be taken:
//   load  EXEC writes the sample, no result
//   start EXEC, then EMIT registers the result
//   step  EXEC, then the current pixel and its three right-hand neighbours
//         are read one after another from the single-port elevation RAM
//         (RD_HERE, RD_MID, RD_UP, RD_DN), then the differences and the
//         choice are registered in DIFF and PICK, and EMIT registers the result
// A new item is taken once the previous one has finished; the output register
// holds one result, so a stalled receiver only holds the block when a second
// result is ready before the first is taken.
// Reset clears the load counter, the walk and the output valid flag; the
// elevation RAM is not cleared and must be loaded before a walk reads it.
module greedy_ridge_path_walk_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  grpw_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output grpw_pkg::t_out_item           o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [grpw_pkg::PADDR_W-1:0]  paddr,
    input  logic [grpw_pkg::PDATA_W-1:0]  pwdata,
    output logic [grpw_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import grpw_pkg::*;

    t_dims                    dims;
    t_mem_req                 mem_req;
    logic signed [ELEV_W-1:0] mem_rdata;

    grpw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_dims  (dims)
    );

    grpw_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    grpw_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_dims      (dims),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

endmodule
